>>> design/look_at_view_matrix_macros.svh
// Assertion macros used by the look-at view matrix checker.
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LKV_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("look_at_view_matrix: implication check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define LKV_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("look_at_view_matrix: next-cycle check failed");

`endif

>>> design/lkv_pkg.sv
// Shared types and constants of the look-at view matrix block.
package lkv_pkg;

    localparam int AXIS_ONE   = 16384;
    localparam int ROOT_STEPS = 31;
    localparam int DIV_STEPS  = 15;
    // mag, msb search, scale, square, sum/root seed, root steps, dividend, div steps, sign
    localparam int NORM_LAT   = 5 + ROOT_STEPS + 1 + DIV_STEPS + 1;

    typedef logic signed [15:0] axis_t;

endpackage

>>> design/lkv_norm.sv
// Pipelined normalizer of a signed 3-vector to a Q1.14 unit vector.
module lkv_norm
    import lkv_pkg::*;
#(
    parameter int W = 33
)
(
    input  logic                clk,
    input  logic                en,
    input  logic signed [W-1:0] vec_x,
    input  logic signed [W-1:0] vec_y,
    input  logic signed [W-1:0] vec_z,
    output axis_t               nrm_x,
    output axis_t               nrm_y,
    output axis_t               nrm_z
);

    localparam int PW   = $clog2(W);
    localparam int RS   = ROOT_STEPS;
    localparam int DS   = DIV_STEPS;

    logic signed [W-1:0] vin [0:2];

    logic [W-1:0]   mag1_reg [0:2], mag1_next [0:2];
    logic [2:0]     sgn1_reg, sgn1_next;

    logic [W-1:0]   mag2_reg [0:2], mag2_next [0:2];
    logic [PW-1:0]  p2_reg, p2_next;
    logic           zero2_reg, zero2_next;
    logic [2:0]     sgn2_reg;
    logic [W-1:0]   or_all;

    logic [W+28:0]  wide [0:2];
    logic [29:0]    m3_reg [0:2], m3_next [0:2];
    logic           zero3_reg;
    logic [2:0]     sgn3_reg;

    logic [59:0]    sq4_reg [0:2], sq4_next [0:2];
    logic [29:0]    m4_reg [0:2];
    logic           zero4_reg;
    logic [2:0]     sgn4_reg;

    // square root: entry 0 holds the seed, entries 1..RS one result bit each
    logic [61:0]    rt_x_reg [0:RS], rt_x_next [0:RS];
    logic [61:0]    rt_r_reg [0:RS], rt_r_next [0:RS];
    logic [29:0]    rt_m_reg [0:RS][0:2];
    logic           rt_zero_reg [0:RS];
    logic [2:0]     rt_sgn_reg [0:RS];

    // division: entry 0 holds the dividend, entries 1..DS one quotient bit each
    logic [44:0]    dv_r_reg [0:DS][0:2], dv_r_next [0:DS][0:2];
    logic [14:0]    dv_q_reg [0:DS][0:2], dv_q_next [0:DS][0:2];
    logic [30:0]    dv_len_reg [0:DS];
    logic           dv_zero_reg [0:DS];
    logic [2:0]     dv_sgn_reg [0:DS];

    axis_t          nrm_reg [0:2], nrm_next [0:2];

    assign vin[0] = vec_x;
    assign vin[1] = vec_y;
    assign vin[2] = vec_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sgn1_next[i] = vin[i][W-1];
            mag1_next[i] = vin[i][W-1] ? W'(-vin[i]) : W'(vin[i]);
        end
    end

    // position of the top set bit of the largest magnitude
    always_comb
    begin
        or_all = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        p2_next = '0;
        for (int i = 0; i < W; i++)
        begin
            if (or_all[i])
                p2_next = PW'(i);
        end
        zero2_next = ~|or_all;
        for (int i = 0; i < 3; i++)
            mag2_next[i] = mag1_reg[i];
    end

    // rescale so the top bit lands at bit 29, truncating on right shifts
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wide[i]    = {mag2_reg[i], 29'b0} >> p2_reg;
            m3_next[i] = wide[i][29:0];
            sq4_next[i] = m3_reg[i] * m3_reg[i];
        end
    end

    always_comb
    begin
        rt_x_next[0] = 62'(sq4_reg[0]) + 62'(sq4_reg[1]) + 62'(sq4_reg[2]);
        rt_r_next[0] = '0;
        for (int k = 1; k <= RS; k++)
        begin
            logic [62:0] bitv;
            logic [62:0] trial;
            bitv  = 63'(1) << (62 - 2 * k);
            trial = 63'(rt_r_reg[k-1]) + bitv;
            if (63'(rt_x_reg[k-1]) >= trial)
            begin
                rt_x_next[k] = rt_x_reg[k-1] - trial[61:0];
                rt_r_next[k] = (rt_r_reg[k-1] >> 1) + bitv[61:0];
            end
            else
            begin
                rt_x_next[k] = rt_x_reg[k-1];
                rt_r_next[k] = rt_r_reg[k-1] >> 1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dv_r_next[0][i] = (45'(rt_m_reg[RS][i]) << 14) + 45'(rt_r_reg[RS][30:1]);
            dv_q_next[0][i] = '0;
        end
        for (int j = 1; j <= DS; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic [45:0] dsub;
                dsub = 46'(dv_len_reg[j-1]) << (DS - j);
                if (46'(dv_r_reg[j-1][i]) >= dsub)
                begin
                    dv_r_next[j][i] = dv_r_reg[j-1][i] - dsub[44:0];
                    dv_q_next[j][i] = dv_q_reg[j-1][i] | (15'(1) << (DS - j));
                end
                else
                begin
                    dv_r_next[j][i] = dv_r_reg[j-1][i];
                    dv_q_next[j][i] = dv_q_reg[j-1][i];
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [15:0] qv;
            qv = {1'b0, dv_q_reg[DS][i]};
            if (dv_zero_reg[DS])
                nrm_next[i] = '0;
            else if (dv_sgn_reg[DS][i])
                nrm_next[i] = axis_t'(~qv + 16'd1);
            else
                nrm_next[i] = axis_t'(qv);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg  <= mag1_next;
            sgn1_reg  <= sgn1_next;
            mag2_reg  <= mag2_next;
            p2_reg    <= p2_next;
            zero2_reg <= zero2_next;
            sgn2_reg  <= sgn1_reg;
            m3_reg    <= m3_next;
            zero3_reg <= zero2_reg;
            sgn3_reg  <= sgn2_reg;
            sq4_reg   <= sq4_next;
            m4_reg    <= m3_reg;
            zero4_reg <= zero3_reg;
            sgn4_reg  <= sgn3_reg;

            rt_x_reg       <= rt_x_next;
            rt_r_reg       <= rt_r_next;
            rt_m_reg[0]    <= m4_reg;
            rt_zero_reg[0] <= zero4_reg;
            rt_sgn_reg[0]  <= sgn4_reg;
            for (int k = 1; k <= RS; k++)
            begin
                rt_m_reg[k]    <= rt_m_reg[k-1];
                rt_zero_reg[k] <= rt_zero_reg[k-1];
                rt_sgn_reg[k]  <= rt_sgn_reg[k-1];
            end

            dv_r_reg       <= dv_r_next;
            dv_q_reg       <= dv_q_next;
            dv_len_reg[0]  <= rt_r_reg[RS][30:0];
            dv_zero_reg[0] <= rt_zero_reg[RS];
            dv_sgn_reg[0]  <= rt_sgn_reg[RS];
            for (int j = 1; j <= DS; j++)
            begin
                dv_len_reg[j]  <= dv_len_reg[j-1];
                dv_zero_reg[j] <= dv_zero_reg[j-1];
                dv_sgn_reg[j]  <= dv_sgn_reg[j-1];
            end

            nrm_reg <= nrm_next;
        end
    end

    assign nrm_x = nrm_reg[0];
    assign nrm_y = nrm_reg[1];
    assign nrm_z = nrm_reg[2];

endmodule

>>> design/look_at_view_matrix.sv
// Look-at camera frame: three axes and three translations from eye, target and up.
//
//  channel | handshake          | word
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid/in_stall  | eye, target, up: nine signed Q16.16
//  out     | out_valid/out_stall| right, upaxis, back (Q1.14), shift_* (Q16.16)
//
// One word enters per cycle while in_stall is low; each word passes through 115
// pipeline stages and then the output register. The two normalizers set the
// depth: 31 square-root steps and 15 divide steps each, one bit per stage.
// Reset clears only the valid bits, also those of the output and skid words; no clearing pass.
// Behind the output register sits one skid register, so the pipe keeps moving
// under out_stall until the skid fills; in_stall rises only once the skid is full.
module look_at_view_matrix
    import lkv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] eye_x,
    input  logic signed [31:0] eye_y,
    input  logic signed [31:0] eye_z,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic signed [31:0] up_x,
    input  logic signed [31:0] up_y,
    input  logic signed [31:0] up_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] right_x,
    output logic signed [15:0] right_y,
    output logic signed [15:0] right_z,
    output logic signed [15:0] upaxis_x,
    output logic signed [15:0] upaxis_y,
    output logic signed [15:0] upaxis_z,
    output logic signed [15:0] back_x,
    output logic signed [15:0] back_y,
    output logic signed [15:0] back_z,
    output logic signed [31:0] shift_right,
    output logic signed [31:0] shift_up,
    output logic signed [31:0] shift_back
);

    // stage counts of each section
    localparam int LAT_A   = 1;    // input register, eye - target
    localparam int LAT_C1  = 2;    // up x back: products, differences
    localparam int LAT_U   = 3;    // back x right: products, differences, round
    localparam int LAT_D   = 3;    // dots with eye: products, sums, round/negate/sat
    localparam int TOTAL   = LAT_A + NORM_LAT + LAT_C1 + NORM_LAT + LAT_U + LAT_D;
    localparam int UP_DLY  = NORM_LAT;
    localparam int BK_DLY  = LAT_C1 + NORM_LAT;
    localparam int EYE_DLY = NORM_LAT + LAT_C1 + NORM_LAT + LAT_U;

    typedef struct packed {
        axis_t             rx, ry, rz;
        axis_t             ux, uy, uz;
        axis_t             bx, by, bz;
        logic signed [31:0] sr, su, sb;
    } res_t;

    // Q2.28 cross term to Q1.14, nearest with ties away from zero, clamped to one
    function automatic axis_t rnd_axis(input logic signed [32:0] t);
        logic [32:0] mag;
        logic [18:0] m;
        logic [15:0] mm;
        mag = t[32] ? 33'(-t) : 33'(t);
        m   = 19'((mag + 33'd8192) >> 14);
        if (m > 19'(AXIS_ONE))
            m = 19'(AXIS_ONE);
        mm  = m[15:0];
        return t[32] ? axis_t'(~mm + 16'd1) : axis_t'(mm);
    endfunction

    // negated dot, rounded from Q17.30 to Q16.16 and saturated to 32 bits
    function automatic logic signed [31:0] rnd_shift(input logic signed [49:0] d);
        logic [49:0] mag;
        logic [35:0] m;
        logic [31:0] r;
        mag = d[49] ? 50'(-d) : 50'(d);
        m   = 36'((mag + 50'd8192) >> 14);
        if (d[49])
            r = (m > 36'h07FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
        else
            r = (m > 36'h080000000) ? 32'h80000000 : (~m[31:0] + 32'd1);
        return $signed(r);
    endfunction

    logic               adv;
    logic [TOTAL-1:0]   vld_reg;

    // stage A
    logic signed [31:0] eye_a_reg [0:2];
    logic signed [31:0] up_a_reg [0:2];
    logic signed [32:0] diff_a_reg [0:2];

    logic signed [31:0] up_dly_reg [0:UP_DLY-1][0:2];
    logic signed [31:0] eye_dly_reg [0:EYE_DLY-1][0:2];
    axis_t              bk_dly_reg [0:BK_DLY-1][0:2];

    axis_t              back_n [0:2];
    axis_t              right_n [0:2];

    logic signed [47:0] c1p_reg [0:5];
    logic signed [48:0] c2_reg [0:2];

    logic signed [31:0] u1p_reg [0:5];
    axis_t              u1_bk_reg [0:2], u1_rt_reg [0:2];
    logic signed [32:0] u2_reg [0:2];
    axis_t              u2_bk_reg [0:2], u2_rt_reg [0:2];
    axis_t              u3_up_reg [0:2], u3_bk_reg [0:2], u3_rt_reg [0:2];

    // axis index: 0 right, 1 up, 2 back
    logic signed [47:0] d1p_reg [0:2][0:2];
    axis_t              d1_ax_reg [0:2][0:2];
    logic signed [49:0] d2_reg [0:2];
    axis_t              d2_ax_reg [0:2][0:2];
    logic signed [31:0] d3_sh_reg [0:2];
    axis_t              d3_ax_reg [0:2][0:2];

    res_t               res_in;
    res_t               out_reg, skid_reg;
    logic               out_v_reg, skid_v_reg;
    logic               push;

    assign adv      = !skid_v_reg;
    assign in_stall = skid_v_reg;
    assign push     = vld_reg[TOTAL-1] && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[TOTAL-2:0], in_valid};
    end

    lkv_norm #(.W(33)) u_norm_back (
        .clk   (clk),
        .en    (adv),
        .vec_x (diff_a_reg[0]),
        .vec_y (diff_a_reg[1]),
        .vec_z (diff_a_reg[2]),
        .nrm_x (back_n[0]),
        .nrm_y (back_n[1]),
        .nrm_z (back_n[2])
    );

    lkv_norm #(.W(49)) u_norm_right (
        .clk   (clk),
        .en    (adv),
        .vec_x (c2_reg[0]),
        .vec_y (c2_reg[1]),
        .vec_z (c2_reg[2]),
        .nrm_x (right_n[0]),
        .nrm_y (right_n[1]),
        .nrm_z (right_n[2])
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage A
            eye_a_reg[0]  <= eye_x;
            eye_a_reg[1]  <= eye_y;
            eye_a_reg[2]  <= eye_z;
            up_a_reg[0]   <= up_x;
            up_a_reg[1]   <= up_y;
            up_a_reg[2]   <= up_z;
            diff_a_reg[0] <= 33'(eye_x) - 33'(target_x);
            diff_a_reg[1] <= 33'(eye_y) - 33'(target_y);
            diff_a_reg[2] <= 33'(eye_z) - 33'(target_z);

            // side data waiting for the normalizers
            up_dly_reg[0]  <= up_a_reg;
            eye_dly_reg[0] <= eye_a_reg;
            bk_dly_reg[0]  <= back_n;
            for (int i = 1; i < UP_DLY; i++)
                up_dly_reg[i] <= up_dly_reg[i-1];
            for (int i = 1; i < EYE_DLY; i++)
                eye_dly_reg[i] <= eye_dly_reg[i-1];
            for (int i = 1; i < BK_DLY; i++)
                bk_dly_reg[i] <= bk_dly_reg[i-1];

            // up x back
            c1p_reg[0] <= up_dly_reg[UP_DLY-1][1] * back_n[2];
            c1p_reg[1] <= up_dly_reg[UP_DLY-1][2] * back_n[1];
            c1p_reg[2] <= up_dly_reg[UP_DLY-1][2] * back_n[0];
            c1p_reg[3] <= up_dly_reg[UP_DLY-1][0] * back_n[2];
            c1p_reg[4] <= up_dly_reg[UP_DLY-1][0] * back_n[1];
            c1p_reg[5] <= up_dly_reg[UP_DLY-1][1] * back_n[0];
            c2_reg[0]  <= 49'(c1p_reg[0]) - 49'(c1p_reg[1]);
            c2_reg[1]  <= 49'(c1p_reg[2]) - 49'(c1p_reg[3]);
            c2_reg[2]  <= 49'(c1p_reg[4]) - 49'(c1p_reg[5]);

            // back x right
            u1p_reg[0] <= bk_dly_reg[BK_DLY-1][1] * right_n[2];
            u1p_reg[1] <= bk_dly_reg[BK_DLY-1][2] * right_n[1];
            u1p_reg[2] <= bk_dly_reg[BK_DLY-1][2] * right_n[0];
            u1p_reg[3] <= bk_dly_reg[BK_DLY-1][0] * right_n[2];
            u1p_reg[4] <= bk_dly_reg[BK_DLY-1][0] * right_n[1];
            u1p_reg[5] <= bk_dly_reg[BK_DLY-1][1] * right_n[0];
            u1_bk_reg  <= bk_dly_reg[BK_DLY-1];
            u1_rt_reg  <= right_n;
            u2_reg[0]  <= 33'(u1p_reg[0]) - 33'(u1p_reg[1]);
            u2_reg[1]  <= 33'(u1p_reg[2]) - 33'(u1p_reg[3]);
            u2_reg[2]  <= 33'(u1p_reg[4]) - 33'(u1p_reg[5]);
            u2_bk_reg  <= u1_bk_reg;
            u2_rt_reg  <= u1_rt_reg;
            for (int i = 0; i < 3; i++)
                u3_up_reg[i] <= rnd_axis(u2_reg[i]);
            u3_bk_reg  <= u2_bk_reg;
            u3_rt_reg  <= u2_rt_reg;

            // dots with eye
            d1_ax_reg[0] <= u3_rt_reg;
            d1_ax_reg[1] <= u3_up_reg;
            d1_ax_reg[2] <= u3_bk_reg;
            for (int c = 0; c < 3; c++)
            begin
                d1p_reg[0][c] <= u3_rt_reg[c] * eye_dly_reg[EYE_DLY-1][c];
                d1p_reg[1][c] <= u3_up_reg[c] * eye_dly_reg[EYE_DLY-1][c];
                d1p_reg[2][c] <= u3_bk_reg[c] * eye_dly_reg[EYE_DLY-1][c];
            end
            for (int a = 0; a < 3; a++)
            begin
                d2_reg[a]    <= 50'(d1p_reg[a][0]) + 50'(d1p_reg[a][1]) + 50'(d1p_reg[a][2]);
                d3_sh_reg[a] <= rnd_shift(d2_reg[a]);
            end
            d2_ax_reg <= d1_ax_reg;
            d3_ax_reg <= d2_ax_reg;
        end
    end

    always_comb
    begin
        res_in.rx = d3_ax_reg[0][0];
        res_in.ry = d3_ax_reg[0][1];
        res_in.rz = d3_ax_reg[0][2];
        res_in.ux = d3_ax_reg[1][0];
        res_in.uy = d3_ax_reg[1][1];
        res_in.uz = d3_ax_reg[1][2];
        res_in.bx = d3_ax_reg[2][0];
        res_in.by = d3_ax_reg[2][1];
        res_in.bz = d3_ax_reg[2][2];
        res_in.sr = d3_sh_reg[0];
        res_in.su = d3_sh_reg[1];
        res_in.sb = d3_sh_reg[2];
    end

    // output register with one skid word behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || !out_stall)
        begin
            out_v_reg  <= skid_v_reg || push;
            skid_v_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || !out_stall)
        begin
            if (skid_v_reg)
                out_reg <= skid_reg;
            else if (push)
                out_reg <= res_in;
        end
        else if (push)
        begin
            skid_reg <= res_in;
        end
    end

    assign out_valid   = out_v_reg;
    assign right_x     = out_reg.rx;
    assign right_y     = out_reg.ry;
    assign right_z     = out_reg.rz;
    assign upaxis_x    = out_reg.ux;
    assign upaxis_y    = out_reg.uy;
    assign upaxis_z    = out_reg.uz;
    assign back_x      = out_reg.bx;
    assign back_y      = out_reg.by;
    assign back_z      = out_reg.bz;
    assign shift_right = out_reg.sr;
    assign shift_up    = out_reg.su;
    assign shift_back  = out_reg.sb;

endmodule

>>> design/lkv_checker.sv
// Port-level checker for the look-at view matrix, bound to the top level.
`include "look_at_view_matrix_macros.svh"

module lkv_checker
    import lkv_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] right_x,
    input logic signed [15:0] back_z,
    input logic signed [31:0] shift_back
);

    // held word stays presented and its shift_back unchanged
    `LKV_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
    `LKV_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(shift_back))
    // input backpressure only once a finished word is waiting
    `LKV_ASSERT_IMP(a_stall_full, in_stall, out_valid)
    // right_x and back_z never exceed one in magnitude
    `LKV_ASSERT_IMP(a_rx_range, out_valid, right_x <= AXIS_ONE && right_x >= -AXIS_ONE)
    `LKV_ASSERT_IMP(a_bz_range, out_valid, back_z <= AXIS_ONE && back_z >= -AXIS_ONE)

endmodule

bind look_at_view_matrix lkv_checker u_lkv_checker (.*);
